// ----- hdl/dzs_pkg.sv -----
package dzs_pkg;

	// Q1.15 full deflection. It also fits a 16-bit unsigned magnitude.
	localparam logic [15:0] Q_ONE = 16'h8000;

	// Reset value of the full-scale register.
	localparam logic [15:0] FULL_SCALE_RESET = 16'h8000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NX,
		ST_NY,
		ST_CX,
		ST_CY,
		ST_CAL,
		ST_EMIT
	} state_t;

	// Request to the shared divider. The quotient is min(Q_ONE, dividend * 2^15 / divisor).
	typedef struct packed {
		logic        start;
		logic [15:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [15:0] quotient;
	} div_rsp_t;

	// Magnitude of a two's complement reading. The most negative value gives 0x8000.
	function automatic logic [15:0] abs_mag(input logic [15:0] raw);
		logic [15:0] u;
		u = raw;
		return raw[15] ? (~u + 16'd1) : u;
	endfunction

	// Attach the sign of the raw reading to a magnitude of at most Q_ONE.
	function automatic logic [16:0] apply_sign(input logic neg, input logic [15:0] mag);
		logic [16:0] m;
		m = {1'b0, mag};
		return neg ? (~m + 17'd1) : m;
	endfunction

endpackage

// ----- hdl/dzs_div.sv -----
module dzs_div (
	input  logic              clk,
	input  logic              arst_n,
	input  dzs_pkg::div_req_t req,
	output dzs_pkg::div_rsp_t rsp
);

	logic [15:0] rem_q;
	logic [15:0] quo_q;
	logic [15:0] nbits_q;
	logic [15:0] dsr_q;
	logic [2:0]  cnt_q;
	logic        busy_q;
	logic        sat_q;
	logic        done_q;

	logic [16:0] trial1;
	logic [16:0] trial2;
	logic        ge1;
	logic        ge2;
	logic [15:0] rem1;
	logic [15:0] rem2;

	// Two restoring steps per cycle.
	always_comb begin
		trial1 = {rem_q, nbits_q[15]};
		ge1    = trial1 >= {1'b0, dsr_q};
		rem1   = ge1 ? 16'(trial1 - {1'b0, dsr_q}) : trial1[15:0];
		trial2 = {rem1, nbits_q[14]};
		ge2    = trial2 >= {1'b0, dsr_q};
		rem2   = ge2 ? 16'(trial2 - {1'b0, dsr_q}) : trial2[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The upper half of the dividend (a * 2^15) is a >> 1 and only bit 15 of the
	// lower half can be set. The quotient exceeds 16 bits exactly when a >= 2d.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q   <= {1'b0, req.dividend[15:1]};
			nbits_q <= {req.dividend[0], 15'd0};
			dsr_q   <= req.divisor;
			sat_q   <= {1'b0, req.dividend} >= {req.divisor, 1'b0};
			quo_q   <= '0;
		end else if (busy_q) begin
			rem_q   <= rem2;
			nbits_q <= {nbits_q[13:0], 2'b00};
			quo_q   <= {quo_q[13:0], ge1, ge2};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = (sat_q || quo_q > dzs_pkg::Q_ONE) ? dzs_pkg::Q_ONE : quo_q;

endmodule

// ----- hdl/stick_axis_deadzone_scaler_unit.sv -----
// Channel  Handshake              Payload
// -------  ---------------------  -----------------------------------------
// input    in_valid / in_ready    cmd, stick_index, raw_x, raw_y
// output   out_valid / out_ready  out_stick, out_x, out_y
// config   cfg_valid / cfg_ready  cfg_data (full_scale)
//
// A sample transaction runs four divisions on the one shared divider,
// which retires two quotient bits per cycle: after acceptance both axes
// are normalized to full scale, then each is rescaled past its deadzone,
// and the result register is loaded. An axis that sits inside its
// deadzone skips its second division. A calibration transaction runs
// only the two normalizing divisions and then updates its deadzones.
// The deadzone tables and control state clear at once on arst_n; no
// clearing pass follows. The result register lets the next input
// transaction start while a result waits; only a second finished result
// stalls the sequencer until the first is taken. Configuration is always
// accepted.
module stick_axis_deadzone_scaler_unit #(
	parameter int NUM_STICKS = 4
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic [1:0]         stick_index,
	input  logic signed [15:0] raw_x,
	input  logic signed [15:0] raw_y,

	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         out_stick,
	output logic signed [16:0] out_x,
	output logic signed [16:0] out_y,

	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data
);

	dzs_pkg::state_t   state_q;
	dzs_pkg::state_t   state_d;
	dzs_pkg::div_req_t div_req;
	dzs_pkg::div_rsp_t div_rsp;

	logic [15:0] full_scale_q;
	logic [15:0] fs_eff;

	// Latched transaction fields.
	logic        cmd_q;
	logic [1:0]  stick_q;
	logic [15:0] raw_x_q;
	logic [15:0] raw_y_q;

	// Normalized and conditioned magnitudes.
	logic [15:0] mx_q;
	logic [15:0] my_q;
	logic [15:0] rx_q;
	logic [15:0] ry_q;
	logic        started_q;

	logic [15:0] dz_x_q [NUM_STICKS];
	logic [15:0] dz_y_q [NUM_STICKS];
	logic [15:0] dzx_rd;
	logic [15:0] dzy_rd;

	logic        out_valid_q;
	logic [1:0]  out_stick_q;
	logic [16:0] out_x_q;
	logic [16:0] out_y_q;

	logic        stick_ok;
	logic        live_x;
	logic        live_y;
	logic        ld_in;
	logic        ld_mx;
	logic        ld_my;
	logic        ld_rx;
	logic        ld_ry;
	logic        cal_wr;
	logic        out_load;

	dzs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// A full scale of zero behaves as one.
	assign fs_eff    = (full_scale_q == 16'd0) ? 16'd1 : full_scale_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= dzs_pkg::FULL_SCALE_RESET;
		end else if (cfg_valid) begin
			full_scale_q <= cfg_data;
		end
	end

	// Transactions for sticks beyond the table are dropped in the idle state.
	assign stick_ok = 32'(stick_index) < NUM_STICKS;

	always_comb begin
		dzx_rd = '0;
		dzy_rd = '0;
		for (int i = 0; i < NUM_STICKS; i++) begin
			if (32'(stick_q) == i) begin
				dzx_rd = dz_x_q[i];
				dzy_rd = dz_y_q[i];
			end
		end
	end

	// An axis needs its rescaling division only when it leaves the deadzone.
	assign live_x = mx_q > dzx_rd;
	assign live_y = my_q > dzy_rd;

	always_comb begin
		state_d = state_q;
		case (state_q)
			dzs_pkg::ST_IDLE: begin
				if (in_valid && stick_ok) begin
					state_d = dzs_pkg::ST_NX;
				end
			end
			dzs_pkg::ST_NX: begin
				if (div_rsp.done) begin
					state_d = dzs_pkg::ST_NY;
				end
			end
			dzs_pkg::ST_NY: begin
				if (div_rsp.done) begin
					state_d = cmd_q ? dzs_pkg::ST_CAL : dzs_pkg::ST_CX;
				end
			end
			dzs_pkg::ST_CX: begin
				if (div_rsp.done || !live_x) begin
					state_d = dzs_pkg::ST_CY;
				end
			end
			dzs_pkg::ST_CY: begin
				if (div_rsp.done || !live_y) begin
					state_d = dzs_pkg::ST_EMIT;
				end
			end
			dzs_pkg::ST_CAL: begin
				state_d = dzs_pkg::ST_IDLE;
			end
			dzs_pkg::ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					state_d = dzs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dzs_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready         = 1'b0;
		ld_in            = 1'b0;
		ld_mx            = 1'b0;
		ld_my            = 1'b0;
		ld_rx            = 1'b0;
		ld_ry            = 1'b0;
		cal_wr           = 1'b0;
		out_load         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = dzs_pkg::abs_mag(raw_x_q);
		div_req.divisor  = fs_eff;
		case (state_q)
			dzs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				ld_in    = in_valid;
			end
			dzs_pkg::ST_NX: begin
				div_req.start = !started_q;
				ld_mx         = div_rsp.done;
			end
			dzs_pkg::ST_NY: begin
				div_req.dividend = dzs_pkg::abs_mag(raw_y_q);
				div_req.start    = !started_q;
				ld_my            = div_rsp.done;
			end
			dzs_pkg::ST_CX: begin
				div_req.dividend = mx_q - dzx_rd;
				div_req.divisor  = dzs_pkg::Q_ONE - dzx_rd;
				div_req.start    = live_x && !started_q;
				ld_rx            = div_rsp.done || !live_x;
			end
			dzs_pkg::ST_CY: begin
				div_req.dividend = my_q - dzy_rd;
				div_req.divisor  = dzs_pkg::Q_ONE - dzy_rd;
				div_req.start    = live_y && !started_q;
				ld_ry            = div_rsp.done || !live_y;
			end
			dzs_pkg::ST_CAL: begin
				cal_wr = 1'b1;
			end
			dzs_pkg::ST_EMIT: begin
				out_load = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dzs_pkg::ST_IDLE;
			started_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (div_rsp.done) begin
				started_q <= 1'b0;
			end else if (div_req.start) begin
				started_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_in) begin
			cmd_q   <= cmd;
			stick_q <= stick_index;
			raw_x_q <= raw_x;
			raw_y_q <= raw_y;
		end
		if (ld_mx) begin
			mx_q <= div_rsp.quotient;
		end
		if (ld_my) begin
			my_q <= div_rsp.quotient;
		end
		if (ld_rx) begin
			rx_q <= live_x ? div_rsp.quotient : 16'd0;
		end
		if (ld_ry) begin
			ry_q <= live_y ? div_rsp.quotient : 16'd0;
		end
	end

	// Calibration only ever raises a deadzone to the peak magnitude seen.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STICKS; i++) begin
				dz_x_q[i] <= '0;
				dz_y_q[i] <= '0;
			end
		end else if (cal_wr) begin
			for (int i = 0; i < NUM_STICKS; i++) begin
				if (32'(stick_q) == i) begin
					if (dz_x_q[i] < mx_q) begin
						dz_x_q[i] <= mx_q;
					end
					if (dz_y_q[i] < my_q) begin
						dz_y_q[i] <= my_q;
					end
				end
			end
		end
	end

	// Result register. It separates the sequencer from the consumer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_stick_q <= stick_q;
			out_x_q     <= dzs_pkg::apply_sign(raw_x_q[15], rx_q);
			out_y_q     <= dzs_pkg::apply_sign(raw_y_q[15], ry_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_stick = out_stick_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;

	// A new transaction must never arrive while the divider is still running.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> !div_rsp.busy)
		else $error("input accepted while the divider is busy");

	// The divider only finishes in a state that is waiting for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == dzs_pkg::ST_NX || state_q == dzs_pkg::ST_NY ||
			state_q == dzs_pkg::ST_CX || state_q == dzs_pkg::ST_CY))
		else $error("divider finished outside a division state");

	// Conditioned results never leave the range of plus or minus one.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_x <= 17'sd32768 && out_x >= -17'sd32768 &&
			out_y <= 17'sd32768 && out_y >= -17'sd32768))
		else $error("conditioned result out of range");

	// Stored deadzones stay within full deflection.
	assert property (@(posedge clk) disable iff (!arst_n)
		(dzx_rd <= dzs_pkg::Q_ONE && dzy_rd <= dzs_pkg::Q_ONE))
		else $error("deadzone above full deflection");

endmodule

// ----- tb/sv/tb_top.sv -----
// One expected conditioned sample: the stick it belongs to and both Q1.15 axes.
typedef struct packed {
	logic [1:0]         stick;
	logic signed [16:0] x;
	logic signed [16:0] y;
} stick_result_t;

// Tracks the full-scale register and both deadzone tables, and keeps the
// conditioned samples that are still owed by the block.
class dz_scoreboard;
	localparam longint unsigned ONE = 32768;
	localparam int STICKS = 4;

	logic [15:0]     full_scale;
	logic [15:0]     dz_x [STICKS];
	logic [15:0]     dz_y [STICKS];
	stick_result_t   owed_q [$];
	int unsigned     mismatches;

	function new();
		full_scale = dzs_pkg::FULL_SCALE_RESET;
		foreach (dz_x[i]) begin
			dz_x[i] = '0;
			dz_y[i] = '0;
		end
		mismatches = 0;
	endfunction

	function void write_full_scale(logic [15:0] value);
		full_scale = value;
	endfunction

	// Magnitude scaled to Q1.15 and saturated at full deflection.
	function logic [15:0] norm_q15(logic signed [15:0] raw);
		int              r;
		longint unsigned mag;
		longint unsigned fs;
		longint unsigned q;
		r = raw;
		mag = (r < 0) ? -r : r;
		fs = (full_scale == 0) ? 1 : full_scale;
		q = mag * ONE / fs;
		return (q > ONE) ? 16'h8000 : q[15:0];
	endfunction

	function logic signed [16:0] cond_axis(logic signed [15:0] raw, logic [15:0] dz);
		longint unsigned m;
		longint unsigned d;
		longint unsigned r;
		logic [16:0]     v;
		m = norm_q15(raw);
		d = dz;
		r = 0;
		if (m > d) begin
			r = (m - d) * ONE / (ONE - d);
			if (r > ONE)
				r = ONE;
		end
		v = r[16:0];
		if (raw[15])
			v = -v;
		return v;
	endfunction

	function void note_input(bit cal, logic [1:0] id, logic signed [15:0] raw_x,
			logic signed [15:0] raw_y);
		stick_result_t e;
		logic [15:0]   mx;
		logic [15:0]   my;
		if (id >= STICKS)
			return;
		if (cal) begin
			mx = norm_q15(raw_x);
			my = norm_q15(raw_y);
			if (dz_x[id] < mx)
				dz_x[id] = mx;
			if (dz_y[id] < my)
				dz_y[id] = my;
			return;
		end
		e.stick = id;
		e.x = cond_axis(raw_x, dz_x[id]);
		e.y = cond_axis(raw_y, dz_y[id]);
		owed_q.push_back(e);
	endfunction

	function void check_result(logic [1:0] stick, logic signed [16:0] x,
			logic signed [16:0] y);
		stick_result_t e;
		if (owed_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: stick %0d x %0d y %0d", stick, x, y);
			return;
		end
		e = owed_q.pop_front();
		if (e.stick !== stick || e.x !== x || e.y !== y) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected stick %0d x %0d y %0d, got stick %0d x %0d y %0d",
					e.stick, e.x, e.y, stick, x, y);
		end
	endfunction
endclass

module tb_top;

	// Sender pauses are up to this long, so they land on every cycle of the
	// block's sequence.
	localparam int MAX_GAP = 45;
	// This covers a calibration transaction still in flight after the last result.
	localparam int SETTLE = 60;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASES = 9;
	localparam int PHASE_ITEMS = 115;
	localparam int CAL_PCT = 6;
	localparam int LIMIT = 600000;

	logic               clk;
	logic               arst_n = 1'b0;

	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               cmd = 1'b0;
	logic [1:0]         stick_index = '0;
	logic signed [15:0] raw_x = '0;
	logic signed [15:0] raw_y = '0;

	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         out_stick;
	logic signed [16:0] out_x;
	logic signed [16:0] out_y;

	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [15:0]        cfg_data = '0;

	dz_scoreboard board = new();

	// When calm is set neither side idles; hold_req asks the receiver for one
	// long hold-off so that the block backs up into its input.
	bit                 calm = 1'b0;
	bit                 hold_req = 1'b0;
	logic [15:0]        cur_fs = dzs_pkg::FULL_SCALE_RESET;
	int unsigned        cycle_count = 0;

	logic [15:0] fs_plan [PHASES] = '{16'd16384, 16'd1, 16'd0, 16'd65535, 16'd1000,
		16'd32768, 16'd24000, 16'd300, 16'd50000};

	stick_axis_deadzone_scaler_unit #(
		.NUM_STICKS(4)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.stick_index(stick_index),
		.raw_x      (raw_x),
		.raw_y      (raw_y),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_stick  (out_stick),
		.out_x      (out_x),
		.out_y      (out_y),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The monitor samples at the rising edge, before any driver or block
	// update of that edge takes effect, so it sees exactly the values that
	// decided each handshake. A result can never stem from an input taken at
	// the same edge, so the order of the two checks below does not matter.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				board.write_full_scale(cfg_data);
			if (out_valid && out_ready)
				board.check_result(out_stick, out_x, out_y);
			if (in_valid && in_ready)
				board.note_input(cmd, stick_index, raw_x, raw_y);
		end
	end

	// Watchdog: a lost result or a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// Result side. It idles at random unless calm, and once per run holds off
	// for a long stretch counted here, while the sender keeps offering work.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 19);
			end
		end
	end

	// Offers one input transaction and returns at the edge that accepts it.
	// in_valid stays high afterwards so back-to-back transactions need no gap.
	task automatic send_item(input bit c, input logic [1:0] id, input logic signed [15:0] x,
			input logic signed [15:0] y);
		if (!calm && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(MAX_GAP, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		stick_index <= id;
		raw_x <= x;
		raw_y <= y;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic set_full_scale(input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Stops offering input until every owed result has arrived, then gives a
	// trailing calibration transaction time to finish as well.
	task automatic quiesce();
		in_valid <= 1'b0;
		do @(posedge clk); while (board.owed_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic int unsigned fs_span();
		int unsigned span;
		span = (cur_fs == 0) ? 1 : cur_fs;
		return (span > 32768) ? 32768 : span;
	endfunction

	// Applies a random sign to a magnitude of at most full deflection.
	function automatic logic signed [15:0] with_sign(input int unsigned mag);
		int v;
		v = mag;
		if ($urandom_range(1))
			v = -v;
		else if (v > 32767)
			v = 32767;
		return v[15:0];
	endfunction

	// Sample readings: the field extremes, fully random words, and values
	// inside the current full-scale span so that small spans still give
	// results between zero and full deflection.
	function automatic logic signed [15:0] sample_raw();
		logic [31:0] w;
		int unsigned pick;
		w = $urandom;
		pick = $urandom_range(9);
		if (pick == 0) begin
			case (w[2:0])
				3'd0: return 16'sh7fff;
				3'd1: return 16'sh8000;
				3'd2: return 16'sh0000;
				3'd3: return 16'shffff;
				3'd4: return 16'sh0001;
				3'd5: return with_sign(fs_span());
				default: return w[15:0];
			endcase
		end else if (pick <= 5) begin
			return w[15:0];
		end
		return with_sign($urandom_range(fs_span()));
	endfunction

	// Calibration readings stay at most an eighth of the span, so the deadzones
	// grow slowly and most sticks keep a wide live range for the whole run.
	function automatic logic signed [15:0] cal_raw();
		return with_sign($urandom_range(fs_span() / 8));
	endfunction

	task automatic random_item();
		logic [31:0] w;
		bit          c;
		w = $urandom;
		c = ($urandom_range(99) < CAL_PCT);
		if (c)
			send_item(c, w[1:0], cal_raw(), cal_raw());
		else
			send_item(c, w[1:0], sample_raw(), sample_raw());
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_full_scale(dzs_pkg::FULL_SCALE_RESET);

		// Directed part at the reset full scale. Fresh sticks have no deadzone,
		// so the extremes pass straight through.
		send_item(1'b0, 2'd0, 16'sh7fff, 16'sh8000);
		send_item(1'b0, 2'd1, 16'sh0000, 16'shffff);
		send_item(1'b0, 2'd2, 16'sh0001, -16'sd32767);
		send_item(1'b0, 2'd3, -16'sd16384, 16'sd16384);
		// Calibrate stick 1, then probe on, just past and far beyond its edge.
		send_item(1'b1, 2'd1, 16'sd4096, -16'sd8192);
		send_item(1'b0, 2'd1, 16'sd4096, -16'sd8192);
		send_item(1'b0, 2'd1, 16'sd4097, -16'sd8193);
		send_item(1'b0, 2'd1, 16'sh8000, 16'sh7fff);
		// A deadzone at full deflection on the X axis of stick 3 kills that
		// axis for good, while its Y axis keeps a narrow deadzone.
		send_item(1'b1, 2'd3, 16'sh8000, 16'sd100);
		send_item(1'b0, 2'd3, 16'sh7fff, 16'sd200);
		send_item(1'b0, 2'd3, 16'sh8000, 16'sh8000);
		// A zero calibration leaves stick 0 unchanged.
		send_item(1'b1, 2'd0, 16'sh0000, 16'sh0000);
		send_item(1'b1, 2'd2, 16'shffff, 16'sh0001);
		send_item(1'b0, 2'd2, 16'sh0001, -16'sd2);
		send_item(1'b0, 2'd0, 16'sh5555, 16'shaaaa);
		send_item(1'b0, 2'd2, 16'shaaaa, 16'sh5555);

		// Random phases, each under its own full scale, among them the
		// smallest, zero (read as one) and the largest the register holds.
		for (int p = 0; p < PHASES; p++) begin
			quiesce();
			cur_fs = (p == 6) ? 16'($urandom_range(65535, 1)) : fs_plan[p];
			set_full_scale(cur_fs);
			calm = (p == 4);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (p == 1 && k == 20)
					hold_req = 1'b1;
				if (p == 3 && k == 60)
					quiesce();
				random_item();
			end
		end
		calm = 1'b0;
		quiesce();

		if (board.mismatches == 0 && board.owed_q.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
